FILE: sv/pcx_pkg.sv
// shared types and constants of the pcx run-length line encoder
package pcx_pkg;

    localparam int unsigned MAX_RUN_DEF = 63;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned TOKENS = 3;

    localparam logic [7:0] COUNT_TAG = 8'hC0;
    localparam logic [7:0] ESCAPE_BYTE = 8'hC1;
    localparam logic [15:0] WIDTH_RESET = 16'd1;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] len;
    } t_run;

    typedef struct packed {
        logic [TOKENS-1:0] tok_vld;
        t_run [TOKENS-1:0] tok;
        logic              line_end;
    } t_entry;

endpackage

FILE: sv/pcx_ifs.sv
// valid/ready channel interfaces for pixels in and encoded bytes out
interface pcx_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface pcx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       line_end;
    logic       last;

    modport source (output valid, output out_byte, output line_end, output last, input ready);
    modport sink (input valid, input out_byte, input line_end, input last, output ready);
endinterface

FILE: sv/pcx_front.sv
// front end: run tracking, line column counter, run tokens per pixel
module pcx_front #(
    parameter int unsigned MAX_RUN = pcx_pkg::MAX_RUN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    pcx_pix_if.sink         i_pix,
    input  logic            i_full,
    output logic            o_push,
    output pcx_pkg::t_entry o_entry
);
    import pcx_pkg::*;

    localparam logic [5:0] MaxLen = 6'(MAX_RUN);

    logic [15:0] r_width;
    logic [7:0]  r_val, n_val;
    logic [5:0]  r_len, n_len;
    logic [15:0] r_col, n_col;
    t_entry      entry;
    logic        accept;

    assign i_pix.ready = !i_full;
    assign accept = i_pix.valid && i_pix.ready;

    always_comb begin
        logic [7:0]  v1, v2;
        logic [5:0]  l1, l2;
        logic [15:0] end_col;
        entry = '0;
        end_col = r_width - 16'd1;
        // extend the open run or close it and start a new one
        if (r_len != 6'd0 && i_pix.pixel == r_val && r_len < MaxLen) begin
            v1 = r_val;
            l1 = r_len + 6'd1;
        end else begin
            if (r_len != 6'd0) begin
                entry.tok_vld[0] = 1'b1;
                entry.tok[0].value = r_val;
                entry.tok[0].len = r_len;
            end
            v1 = i_pix.pixel;
            l1 = 6'd1;
        end
        v2 = v1;
        l2 = l1;
        if (r_col == end_col) begin
            // odd width: a zero pad pixel joins the line
            if (r_width[0]) begin
                if (v1 == 8'd0 && l1 < MaxLen) begin
                    l2 = l1 + 6'd1;
                end else begin
                    entry.tok_vld[1] = 1'b1;
                    entry.tok[1].value = v1;
                    entry.tok[1].len = l1;
                    v2 = 8'd0;
                    l2 = 6'd1;
                end
            end
            entry.tok_vld[2] = 1'b1;
            entry.tok[2].value = v2;
            entry.tok[2].len = l2;
            entry.line_end = 1'b1;
            n_val = v2;
            n_len = 6'd0;
            n_col = 16'd0;
        end else begin
            n_val = v1;
            n_len = l1;
            n_col = r_col + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_val <= 8'd0;
            r_len <= 6'd0;
            r_col <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_data;
            end
            if (accept) begin
                r_val <= n_val;
                r_len <= n_len;
                r_col <= n_col;
            end
        end
    end

    assign o_push = accept && (entry.tok_vld != '0);
    assign o_entry = entry;

endmodule

FILE: sv/pcx_queue.sv
// short token queue between front and back end
module pcx_queue #(
    parameter int unsigned DEPTH = pcx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcx_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output pcx_pkg::t_entry o_head,
    output logic            o_empty
);
    import pcx_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/pcx_back.sv
// back end: turns queued run tokens into bytes, one byte per cycle while the output is ready
module pcx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcx_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    pcx_byte_if.source      o_byte
);
    import pcx_pkg::*;

    logic [1:0] r_slot;
    logic       r_phase;
    logic       r_ovld;
    logic [7:0] r_obyte;
    logic       r_oend;
    logic       r_olast;

    logic [1:0] cur;
    logic       later;
    logic       two_byte;
    logic       tok_done;
    logic       ent_done;
    logic       advance;
    logic [7:0] byte_out;
    t_run       run;

    always_comb begin
        logic found;
        found = 1'b0;
        cur = r_slot;
        later = 1'b0;
        for (int i = 0; i < TOKENS; i++) begin
            if (!found && 2'(i) >= r_slot && i_head.tok_vld[i]) begin
                cur = 2'(i);
                found = 1'b1;
            end else if (found && i_head.tok_vld[i]) begin
                later = 1'b1;
            end
        end
    end

    assign run = i_head.tok[cur];
    assign two_byte = (run.len >= 6'd2) || (run.value >= COUNT_TAG);
    assign tok_done = r_phase || !two_byte;
    assign ent_done = tok_done && !later;
    assign advance = !i_empty && (!r_ovld || o_byte.ready);
    assign o_pop = advance && ent_done;

    always_comb begin
        if (r_phase) begin
            byte_out = run.value;
        end else if (run.len >= 6'd2) begin
            byte_out = COUNT_TAG | {2'b00, run.len};
        end else if (run.value >= COUNT_TAG) begin
            byte_out = ESCAPE_BYTE;
        end else begin
            byte_out = run.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 2'd0;
            r_phase <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (advance) begin
                r_ovld <= 1'b1;
                if (ent_done) begin
                    r_slot <= 2'd0;
                    r_phase <= 1'b0;
                end else if (tok_done) begin
                    r_slot <= cur + 2'd1;
                    r_phase <= 1'b0;
                end else begin
                    r_slot <= cur;
                    r_phase <= 1'b1;
                end
            end else if (o_byte.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_obyte <= byte_out;
            r_olast <= ent_done;
            r_oend <= ent_done && i_head.line_end;
        end
    end

    assign o_byte.valid = r_ovld;
    assign o_byte.out_byte = r_obyte;
    assign o_byte.line_end = r_oend;
    assign o_byte.last = r_olast;

endmodule

FILE: sv/pcx_rle_line_encoder.sv
// pcx run-length line encoder top level
// path: tokens are registered in the token queue, then bytes in the back end output register
// throughput: one pixel request per cycle while the token queue has room; one byte per cycle
//   out while the output is ready, and a pixel yields up to 5 bytes
// the output byte rate of the back end, buffered by the token queue, sets sustained rate
// reset: synchronous active low; clears run state, column, queue and output; width back to 1
module pcx_rle_line_encoder #(
    parameter int unsigned MAX_RUN = pcx_pkg::MAX_RUN_DEF,
    parameter int unsigned QUEUE_DEPTH = pcx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    pcx_pix_if.sink     i_pix,
    pcx_byte_if.source  o_byte
);
    import pcx_pkg::*;

    // tokens of one pixel request, pushed by the front end
    logic   q_push;
    t_entry q_in;
    logic   q_full;
    // head of the queue, drained by the back end
    logic   q_pop;
    t_entry q_head;
    logic   q_empty;

    // front end keeps the open run and the column, and splits each pixel
    // into up to three closed runs: the run it ends, the run closed by the
    // zero pad of an odd line, and the run flushed at line end
    pcx_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // decouples pixel intake from byte output
    pcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // back end emits count, escape and value bytes through an output register
    pcx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_byte  (o_byte)
    );

`ifndef ASSERT_OFF
    // the front end never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("token queue overflow");

    // nothing is popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("token queue underflow");

    // retiring an entry always presents its final byte next
    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_byte.valid && o_byte.last))
        else $error("entry retired without final byte");

    // a line end marker only rides on the final byte of a request
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.line_end) |-> o_byte.last)
        else $error("line end on a non-final byte");
`endif

endmodule
